// ----- hw/rtl/rgb_2d_convolution_stream_defines.svh -----
// Assertion macros shared by the checker files of the convolution stream.
// Needs a clk and an rst signal in the scope where a macro is used.
`ifndef RGB_2D_CONVOLUTION_STREAM_DEFINES_SVH
`define RGB_2D_CONVOLUTION_STREAM_DEFINES_SVH

// check that is switched off while reset is high
`define RGBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also runs through reset
`define RGBC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/rgbc_pkg.sv -----
// Types, constants and helpers of the RGB convolution stream.
// No dependencies; imported by every RTL module of the block.
package rgbc_pkg;

  localparam int KERNEL_SIZE    = 3;
  localparam int RADIUS         = KERNEL_SIZE / 2;
  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_ROWS       = 4096;
  localparam int COEF_FRAC_BITS = 8;
  localparam int COEF_BITS      = 12;
  localparam int LINE_AW        = $clog2(MAX_WIDTH);
  localparam int ROWSEL_W       = $clog2(KERNEL_SIZE);
  localparam int PROD_W         = COEF_BITS + 9;
  localparam int SUM_W          = PROD_W + $clog2(KERNEL_SIZE * KERNEL_SIZE);
  localparam int COL_W          = 10;
  localparam int ROW_W          = 12;
  localparam int WIDTH_W        = 11;
  localparam int HEIGHT_W       = 13;
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = 60;
  localparam int FIFO_DEPTH     = 16;
  localparam int FIFO_AW        = $clog2(FIFO_DEPTH);

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_COEF_ROW0    = 3'd2,
    REG_COEF_ROW1    = 3'd3,
    REG_COEF_ROW2    = 3'd4,
    REG_COEF_ROW3    = 3'd5,
    REG_COEF_ROW4    = 3'd6
  } reg_index_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_t;

  // one window column, index 0 is the oldest row
  typedef pix_t [KERNEL_SIZE-1:0] wcol_t;

  // coefficients of one window column, index is the kernel row
  typedef logic [KERNEL_SIZE-1:0][COEF_BITS-1:0] ccol_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] r;
    logic signed [SUM_W-1:0] g;
    logic signed [SUM_W-1:0] b;
  } csum_t;

  // one queued result word
  typedef struct packed {
    pix_t             pix;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } out_word_t;

  // drop the fraction and saturate to 0..255
  function automatic logic [7:0] clamp_sum(input logic signed [SUM_W-1:0] s);
    logic [7:0] q;
    if (s <= 0) begin
      q = 8'd0;
    end else if (s[SUM_W-1:COEF_FRAC_BITS+8] != '0) begin
      q = 8'hFF;
    end else begin
      q = s[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
    end
    return q;
  endfunction

endpackage

// ----- hw/rtl/rgbc_line_bank.sv -----
// One row slot of the line store: 1R1W memory with registered read data.
// Depends on rgbc_pkg.
module rgbc_line_bank
  import rgbc_pkg::*;
(
  input  logic               clk,
  input  logic               wr_en,
  input  logic [LINE_AW-1:0] wr_addr,
  input  pix_t               wr_data,
  input  logic               rd_en,
  input  logic [LINE_AW-1:0] rd_addr,
  output pix_t               rd_data
);

  pix_t mem [MAX_WIDTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/rgbc_window_cell.sv -----
// One window column cell: holds a column, hands it on, forms its column sum.
// Depends on rgbc_pkg.
module rgbc_window_cell
  import rgbc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  shift,
  input  logic  calc,
  input  wcol_t col_in,
  input  ccol_t coef,
  output wcol_t col_out,
  output csum_t sum
);

  wcol_t held;
  csum_t acc;

  // column register, shifted once per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (shift) begin
      held <= col_in;
    end
  end

  assign col_out = held;

  // products of this column, summed down the rows
  always_comb begin
    acc = '0;
    for (int ky = 0; ky < KERNEL_SIZE; ky++) begin
      acc.r = acc.r + SUM_W'($signed({1'b0, held[ky].r}) * $signed(coef[ky]));
      acc.g = acc.g + SUM_W'($signed({1'b0, held[ky].g}) * $signed(coef[ky]));
      acc.b = acc.b + SUM_W'($signed({1'b0, held[ky].b}) * $signed(coef[ky]));
    end
  end

  always_ff @(posedge clk) begin
    if (calc) begin
      sum <= acc;
    end
  end

endmodule

// ----- hw/rtl/rgbc_out_fifo.sv -----
// Result queue: up to two words pushed per cycle, one popped.
// Depends on rgbc_pkg.
module rgbc_out_fifo
  import rgbc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push0,
  input  out_word_t        data0,
  input  logic             push1,
  input  out_word_t        data1,
  input  logic             pop,
  output out_word_t        head,
  output logic [FIFO_AW:0] count
);

  out_word_t        mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;

  // storage; second word lands behind the first
  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_ptr] <= data0;
    end
    if (push1) begin
      mem[wr_ptr + FIFO_AW'(1)] <= data1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push0) + FIFO_AW'(push1);
      rd_ptr <= rd_ptr + FIFO_AW'(pop);
      count  <= count + (FIFO_AW+1)'(push0) + (FIFO_AW+1)'(push1) - (FIFO_AW+1)'(pop);
    end
  end

  assign head = mem[rd_ptr];

endmodule

// ----- hw/rtl/rgb_2d_convolution_stream.sv -----
// Top level of the RGB 3x3 sliding-window convolution stream.
// Depends on rgbc_pkg, rgbc_line_bank, rgbc_window_cell, rgbc_out_fifo.
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  input   | in_valid/in_ready   | red_in green_in blue_in start_of_frame
//  output  | out_valid/out_ready | red_out green_out blue_out out_column
//          |                     | out_row last_of_input
//  config  | cfg_write           | cfg_index cfg_data
//
// One pixel per cycle is taken while in_ready is high; a word reaches the result
// queue through the line store read, window column cells and column sum adder.
// A pixel on the right column or bottom row, at or past the third column and
// row, yields two words, so the output port then sets the pace. in_ready drops
// when the 16-word queue plus the words in flight could overflow. Synchronous
// reset clears control, window and config; the line store has no clearing pass.
module rgb_2d_convolution_stream
  import rgbc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             red_in,
  input  logic [7:0]             green_in,
  input  logic [7:0]             blue_in,
  input  logic                   start_of_frame,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             red_out,
  output logic [7:0]             green_out,
  output logic [7:0]             blue_out,
  output logic [COL_W-1:0]       out_column,
  output logic [ROW_W-1:0]       out_row,
  output logic                   last_of_input
);

  // config registers
  logic [WIDTH_W-1:0]    image_width;
  logic [HEIGHT_W-1:0]   image_height;
  logic [CFG_DATA_W-1:0] coef_row [KERNEL_SIZE];

  // position of the next pixel
  logic [COL_W-1:0]    column_count;
  logic [ROW_W-1:0]    row_count;
  logic [ROWSEL_W-1:0] row_slot;

  logic [WIDTH_W-1:0]  w;
  logic [HEIGHT_W-1:0] h;
  logic                accept;
  logic [COL_W-1:0]    c0, c1, col_next;
  logic [ROW_W-1:0]    r0, cur_row, row_next;
  logic [HEIGHT_W-1:0] r1, rn;
  logic [ROWSEL_W-1:0] m0, m1, cur_slot, slot_next;
  logic [WIDTH_W-1:0]  cn;
  logic                border, interior;
  pix_t                in_pix;

  // pipeline stages
  logic                s1_valid, s2_valid, s3_valid;
  pix_t                s1_pix, s2_pix, s3_pix;
  logic [COL_W-1:0]    s1_col, s2_col, s3_col;
  logic [ROW_W-1:0]    s1_row, s2_row, s3_row;
  logic [ROWSEL_W-1:0] s1_slot;
  logic                s1_border, s2_border, s3_border;
  logic                s1_inner, s2_inner, s3_inner;

  pix_t  bank_q   [KERNEL_SIZE];
  wcol_t new_col;
  wcol_t cell_col [KERNEL_SIZE];
  csum_t cell_sum [KERNEL_SIZE];
  ccol_t cell_coef [KERNEL_SIZE];
  csum_t total;

  out_word_t        q_data0, q_data1, q_head;
  logic             q_push0, q_push1, q_pop;
  logic [FIFO_AW:0] q_count;
  logic [FIFO_AW+1:0] q_need;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_W'(640);
      image_height <= HEIGHT_W'(480);
      for (int k = 0; k < KERNEL_SIZE; k++) begin
        coef_row[k] <= '0;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_W-1:0];
        default: begin
          for (int k = 0; k < KERNEL_SIZE; k++) begin
            if (cfg_index == CFG_INDEX_W'(int'(REG_COEF_ROW0) + k)) begin
              coef_row[k] <= cfg_data;
            end
          end
        end
      endcase
    end
  end

  // effective frame size
  always_comb begin
    if (image_width == '0) begin
      w = WIDTH_W'(1);
    end else if (image_width > WIDTH_W'(MAX_WIDTH)) begin
      w = WIDTH_W'(MAX_WIDTH);
    end else begin
      w = image_width;
    end
    if (image_height == '0) begin
      h = HEIGHT_W'(1);
    end else if (image_height > HEIGHT_W'(MAX_ROWS)) begin
      h = HEIGHT_W'(MAX_ROWS);
    end else begin
      h = image_height;
    end
  end

  // position of this pixel, next position, border and interior flags
  always_comb begin
    c0 = start_of_frame ? '0 : column_count;
    r0 = start_of_frame ? '0 : row_count;
    m0 = start_of_frame ? '0 : row_slot;
    if ({1'b0, c0} >= w) begin
      c1 = '0;
      r1 = {1'b0, r0} + HEIGHT_W'(1);
      m1 = (m0 == ROWSEL_W'(KERNEL_SIZE - 1)) ? '0 : m0 + ROWSEL_W'(1);
    end else begin
      c1 = c0;
      r1 = {1'b0, r0};
      m1 = m0;
    end
    if (r1 >= h) begin
      cur_row  = '0;
      cur_slot = '0;
    end else begin
      cur_row  = r1[ROW_W-1:0];
      cur_slot = m1;
    end
    border = (c1 < COL_W'(RADIUS)) || (cur_row < ROW_W'(RADIUS))
          || ({1'b0, c1} + WIDTH_W'(RADIUS) >= w)
          || ({1'b0, cur_row} + HEIGHT_W'(RADIUS) >= h);
    interior = (c1 >= COL_W'(2 * RADIUS)) && (cur_row >= ROW_W'(2 * RADIUS));

    cn = {1'b0, c1} + WIDTH_W'(1);
    rn = {1'b0, cur_row} + HEIGHT_W'(1);
    if (cn >= w) begin
      col_next = '0;
      if (rn >= h) begin
        row_next  = '0;
        slot_next = '0;
      end else begin
        row_next  = rn[ROW_W-1:0];
        slot_next = (cur_slot == ROWSEL_W'(KERNEL_SIZE - 1)) ? '0
                  : cur_slot + ROWSEL_W'(1);
      end
    end else begin
      col_next  = cn[COL_W-1:0];
      row_next  = cur_row;
      slot_next = cur_slot;
    end
  end

  assign accept = in_valid && in_ready;
  assign in_pix = '{r: red_in, g: green_in, b: blue_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      row_slot     <= '0;
    end else if (accept) begin
      column_count <= col_next;
      row_count    <= row_next;
      row_slot     <= slot_next;
    end
  end

  // line store: one bank per row slot
  for (genvar b = 0; b < KERNEL_SIZE; b++) begin : g_bank
    rgbc_line_bank u_bank (
      .clk     (clk),
      .wr_en   (accept && (cur_slot == ROWSEL_W'(b))),
      .wr_addr (c1[LINE_AW-1:0]),
      .wr_data (in_pix),
      .rd_en   (accept),
      .rd_addr (c1[LINE_AW-1:0]),
      .rd_data (bank_q[b])
    );
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix    <= in_pix;
      s1_col    <= c1;
      s1_row    <= cur_row;
      s1_slot   <= cur_slot;
      s1_border <= border;
      s1_inner  <= interior;
    end
    if (s1_valid) begin
      s2_pix    <= s1_pix;
      s2_col    <= s1_col;
      s2_row    <= s1_row;
      s2_border <= s1_border;
      s2_inner  <= s1_inner;
    end
    if (s2_valid) begin
      s3_pix    <= s2_pix;
      s3_col    <= s2_col;
      s3_row    <= s2_row;
      s3_border <= s2_border;
      s3_inner  <= s2_inner;
    end
  end

  // new column: older rows from the store, newest row is the pixel itself
  always_comb begin
    logic [ROWSEL_W:0] idx;
    for (int ky = 0; ky < KERNEL_SIZE - 1; ky++) begin
      idx = {1'b0, s1_slot} + (ROWSEL_W+1)'(ky + 1);
      if (idx >= (ROWSEL_W+1)'(KERNEL_SIZE)) begin
        idx = idx - (ROWSEL_W+1)'(KERNEL_SIZE);
      end
      new_col[ky] = bank_q[idx[ROWSEL_W-1:0]];
    end
    new_col[KERNEL_SIZE-1] = s1_pix;
  end

  // chain of column cells, newest column enters the last cell
  for (genvar kx = 0; kx < KERNEL_SIZE; kx++) begin : g_cell
    for (genvar ky = 0; ky < KERNEL_SIZE; ky++) begin : g_coef
      assign cell_coef[kx][ky] = coef_row[ky][kx*COEF_BITS +: COEF_BITS];
    end
    rgbc_window_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (s1_valid),
      .calc    (s2_valid),
      .col_in  ((kx == KERNEL_SIZE - 1) ? new_col : cell_col[(kx + 1) % KERNEL_SIZE]),
      .coef    (cell_coef[kx]),
      .col_out (cell_col[kx]),
      .sum     (cell_sum[kx])
    );
  end

  // add the column sums
  always_comb begin
    total = '0;
    for (int kx = 0; kx < KERNEL_SIZE; kx++) begin
      total.r = total.r + cell_sum[kx].r;
      total.g = total.g + cell_sum[kx].g;
      total.b = total.b + cell_sum[kx].b;
    end
  end

  // queue words: own copy first for a border pixel, then the interior result
  always_comb begin
    q_data1.pix  = '{r: clamp_sum(total.r), g: clamp_sum(total.g), b: clamp_sum(total.b)};
    q_data1.col  = s3_col - COL_W'(RADIUS);
    q_data1.row  = s3_row - ROW_W'(RADIUS);
    q_data1.last = 1'b1;
    if (s3_border) begin
      q_data0.pix  = s3_pix;
      q_data0.col  = s3_col;
      q_data0.row  = s3_row;
      q_data0.last = !s3_inner;
    end else begin
      q_data0 = q_data1;
    end
    q_push0 = s3_valid && (s3_border || s3_inner);
    q_push1 = s3_valid && s3_border && s3_inner;
  end

  rgbc_out_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push0 (q_push0),
    .data0 (q_data0),
    .push1 (q_push1),
    .data1 (q_data1),
    .pop   (q_pop),
    .head  (q_head),
    .count (q_count)
  );

  // room for two words per pixel in flight plus one more pixel
  assign q_need = (FIFO_AW+2)'(q_count)
                + (FIFO_AW+2)'({s1_valid, 1'b0})
                + (FIFO_AW+2)'({s2_valid, 1'b0})
                + (FIFO_AW+2)'({s3_valid, 1'b0})
                + (FIFO_AW+2)'(2);
  assign in_ready = (q_need <= (FIFO_AW+2)'(FIFO_DEPTH));

  assign out_valid     = (q_count != '0);
  assign q_pop         = out_valid && out_ready;
  assign red_out       = q_head.pix.r;
  assign green_out     = q_head.pix.g;
  assign blue_out      = q_head.pix.b;
  assign out_column    = q_head.col;
  assign out_row       = q_head.row;
  assign last_of_input = q_head.last;

endmodule

// ----- hw/rtl/rgbc_checker.sv -----
// Port-level checks on the convolution stream, bound to its top level.
// Depends on rgbc_pkg and rgb_2d_convolution_stream_defines.svh.
`include "rgb_2d_convolution_stream_defines.svh"

module rgbc_checker
  import rgbc_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [7:0]             red_out,
  input logic [7:0]             green_out,
  input logic [7:0]             blue_out,
  input logic [COL_W-1:0]       out_column,
  input logic [ROW_W-1:0]       out_row,
  input logic                   last_of_input
);

  logic [24+COL_W+ROW_W:0] out_word;
  logic                    pair_spot;

  // whole offered word and the positions where a pair can start
  assign out_word  = {red_out, green_out, blue_out, out_column, out_row, last_of_input};
  assign pair_spot = (out_column >= COL_W'(2 * RADIUS)) && (out_row >= ROW_W'(2 * RADIUS));

  // a stalled word stays offered
  `RGBC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "output word dropped")

  // a stalled word keeps its payload
  `RGBC_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_word), "output word changed")

  // a word that is not last is a border copy followed by an interior result
  `RGBC_ASSERT(a_pair_pos, out_valid && !last_of_input |-> pair_spot, "paired word at wrong spot")

  // reset empties the result queue
  `RGBC_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "output valid after reset")

endmodule

bind rgb_2d_convolution_stream rgbc_checker u_rgbc_checker (.*);
